// ----- sv/lls_pkg.sv -----
// Shared constants, payload types and scan token type for the least-loaded assigner.
package lls_pkg;

    localparam int MAX_SERVERS = 16;
    localparam int LOAD_W      = 32;
    localparam int IDX_W       = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam int CNT_W       = $clog2(MAX_SERVERS + 1);
    localparam int JOB_W       = 16;
    localparam int SRV_W       = 5;

    localparam logic [LOAD_W-1:0] LOAD_MAX = {LOAD_W{1'b1}};

    typedef struct packed {
        logic [JOB_W-1:0] job_time;
        logic             new_batch;
    } job_t;

    typedef struct packed {
        logic [SRV_W-1:0] assigned_server;
        logic [SRV_W-1:0] next_server;
        logic             load_saturated;
    } result_t;

    typedef struct packed {
        logic              go;
        logic              best_valid;
        logic [LOAD_W-1:0] best_load;
        logic [IDX_W-1:0]  best_idx;
        logic              sec_valid;
        logic [LOAD_W-1:0] sec_load;
        logic [IDX_W-1:0]  sec_idx;
    } scan_t;

endpackage

// ----- sv/lls_cell.sv -----
// One server cell: holds that server's load and folds it into the passing minimum scan.
module lls_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  lls_pkg::scan_t            scan_in,
    input  logic                      open,
    input  logic [lls_pkg::IDX_W-1:0] idx,
    input  logic                      clear,
    input  logic                      wr_en,
    input  logic [lls_pkg::LOAD_W-1:0] wr_load,
    output lls_pkg::scan_t            scan_out
);
    import lls_pkg::*;

    logic [LOAD_W-1:0] load_reg;
    logic [LOAD_W-1:0] load_next;
    scan_t             scan_reg;
    scan_t             scan_next;

    always_comb
    begin
        scan_next = scan_in;
        if (open)
        begin
            if (!scan_in.best_valid)
            begin
                scan_next.best_valid = 1'b1;
                scan_next.best_load  = load_reg;
                scan_next.best_idx   = idx;
            end
            else if (load_reg < scan_in.best_load)
            begin
                scan_next.sec_valid  = 1'b1;
                scan_next.sec_load   = scan_in.best_load;
                scan_next.sec_idx    = scan_in.best_idx;
                scan_next.best_load  = load_reg;
                scan_next.best_idx   = idx;
            end
            else if (!scan_in.sec_valid || (load_reg < scan_in.sec_load))
            begin
                scan_next.sec_valid  = 1'b1;
                scan_next.sec_load   = load_reg;
                scan_next.sec_idx    = idx;
            end
        end
    end

    always_comb
    begin
        load_next = load_reg;
        if (clear)
        begin
            load_next = '0;
        end
        else if (wr_en)
        begin
            load_next = wr_load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_reg <= '0;
            scan_reg <= '0;
        end
        else
        begin
            load_reg <= load_next;
            scan_reg <= scan_next;
        end
    end

    assign scan_out = scan_reg;

endmodule

// ----- sv/least_loaded_server_assign.sv -----
// Top level: greedy least-loaded job assignment over a chain of server cells.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------
//  job      | start, busy          | job.job_time, job.new_batch
//  result   | done (1-cycle pulse) | result.assigned_server, next_server,
//           |                      |   load_saturated
//  config   | cfg_we               | cfg_wdata (active_servers)
//
// After a job transfer the scan token walks the cell chain one cell per cycle;
// when it leaves the last cell the job is added to the least load, the next
// server is picked, and the result and strobe are registered. busy stays high from
// transfer until the strobe cycle; a new job may transfer at the edge that ends
// the strobe cycle, so a new job is never taken while one is still in flight.
// Reset clears all loads and sets active_servers to 1. The receiver cannot stall.
module least_loaded_server_assign (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [lls_pkg::SRV_W-1:0]   cfg_wdata,
    input  logic                        start,
    output logic                        busy,
    input  lls_pkg::job_t               job,
    output logic                        done,
    output lls_pkg::result_t            result
);
    import lls_pkg::*;

    logic [SRV_W-1:0]  active_reg;
    logic              busy_reg;
    logic              head_go_reg;
    logic [JOB_W-1:0]  job_reg;
    logic              done_reg;
    result_t           result_reg;
    result_t           result_next;

    logic              accept;
    logic              clear;
    logic [CNT_W-1:0]  n_open;
    logic [31:0]       act32;
    scan_t             chain [0:MAX_SERVERS];
    scan_t             tail;
    logic              fire;
    logic [LOAD_W:0]   sum;
    logic [LOAD_W-1:0] cur;
    logic              sat;
    logic [IDX_W-1:0]  nxt;
    logic [31:0]       who_num;
    logic [31:0]       nxt_num;
    logic [MAX_SERVERS-1:0] go_vec;

    assign accept = start && !busy_reg;
    assign clear  = accept && job.new_batch;

    always_comb
    begin
        act32 = 32'(active_reg);
        if (act32 == 32'd0)
        begin
            act32 = 32'd1;
        end
        else if (act32 > 32'(MAX_SERVERS))
        begin
            act32 = 32'(MAX_SERVERS);
        end
        n_open = CNT_W'(act32);
    end

    assign chain[0] = {head_go_reg, {($bits(scan_t) - 1){1'b0}}};

    assign tail = chain[MAX_SERVERS];
    assign fire = tail.go;

    always_comb
    begin
        sum = {1'b0, tail.best_load} + (LOAD_W+1)'(job_reg);
        if (sum[LOAD_W])
        begin
            cur = LOAD_MAX;
            sat = 1'b1;
        end
        else
        begin
            cur = sum[LOAD_W-1:0];
            sat = 1'b0;
        end
        if (!tail.sec_valid || (cur < tail.sec_load))
        begin
            nxt = tail.best_idx;
        end
        else if (cur == tail.sec_load)
        begin
            nxt = (tail.best_idx < tail.sec_idx) ? tail.best_idx : tail.sec_idx;
        end
        else
        begin
            nxt = tail.sec_idx;
        end
        who_num = 32'(tail.best_idx) + 32'd1;
        nxt_num = 32'(nxt) + 32'd1;
        result_next.assigned_server = who_num[SRV_W-1:0];
        result_next.next_server     = nxt_num[SRV_W-1:0];
        result_next.load_saturated  = sat;
    end

    genvar i;
    generate
        for (i = 0; i < MAX_SERVERS; i++)
        begin : g_cell
            lls_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .scan_in  (chain[i]),
                .open     (CNT_W'(i) < n_open),
                .idx      (IDX_W'(i)),
                .clear    (clear),
                .wr_en    (fire && (tail.best_idx == IDX_W'(i))),
                .wr_load  (cur),
                .scan_out (chain[i+1])
            );
            assign go_vec[i] = chain[i+1].go;
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= SRV_W'(1);
            busy_reg    <= 1'b0;
            head_go_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                active_reg <= cfg_wdata;
            end
            head_go_reg <= accept;
            done_reg    <= fire;
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (fire)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            job_reg <= job.job_time;
        end
        if (fire)
        begin
            result_reg <= result_next;
        end
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = result_reg;

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after job transfer");

    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({go_vec, head_go_reg}))
        else $error("more than one scan token in the cell chain");

    a_fire_done: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> done)
        else $error("scan finished without a result strobe");

    a_token_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (head_go_reg || (go_vec != '0)) |-> busy)
        else $error("scan token present while idle");

endmodule

// ----- tb/least_loaded_server_assign_test.sv -----
// Self-checking testbench for the least-loaded server assigner: directed table, then random jobs.
module least_loaded_server_assign_test;
    import lls_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int SETTLE      = MAX_SERVERS + 4;

    typedef struct {
        bit               set_cfg;
        logic [SRV_W-1:0] servers;
        int               reps;
        job_t             item;
        bit               typed;
        result_t          want;
    } stim_row_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    logic [SRV_W-1:0] cfg_wdata = '0;
    logic             start = 1'b0;
    logic             busy;
    job_t             job = '0;
    logic             done;
    result_t          result;

    logic [LOAD_W-1:0] model_load [MAX_SERVERS];
    logic [SRV_W-1:0]  model_active = SRV_W'(1);
    result_t           pending_results [$];
    stim_row_t         plan [$];

    bit      use_typed = 1'b0;
    result_t typed_want = '0;
    result_t got_want;
    result_t predicted;

    int mismatches = 0;
    int jobs_taken = 0;
    int results_seen = 0;
    int sat_seen = 0;
    int batches_sent = 0;
    int cfg_writes = 0;
    int idle_cycles = 0;

    least_loaded_server_assign u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .start     (start),
        .busy      (busy),
        .job       (job),
        .done      (done),
        .result    (result)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        for (int i = 0; i < MAX_SERVERS; i++)
            model_load[i] = '0;
    end

    function automatic int least_loaded(int open_n);
        int best;
        best = 0;
        for (int i = 1; i < open_n; i++)
            if (model_load[i] < model_load[best])
                best = i;
        return best;
    endfunction

    function automatic result_t predict_assignment(job_t j);
        int               open_n;
        int               who;
        int               nxt;
        logic [LOAD_W:0]  sum;
        result_t          r;
        open_n = (model_active == 0) ? 1 :
                 (model_active > MAX_SERVERS) ? MAX_SERVERS : int'(model_active);
        if (j.new_batch)
            for (int i = 0; i < MAX_SERVERS; i++)
                model_load[i] = '0;
        who = least_loaded(open_n);
        r.load_saturated = 1'b0;
        if (j.job_time != 0)
        begin
            sum = {1'b0, model_load[who]} + (LOAD_W+1)'(j.job_time);
            if (sum > {1'b0, LOAD_MAX})
            begin
                model_load[who]  = LOAD_MAX;
                r.load_saturated = 1'b1;
            end
            else
                model_load[who] = sum[LOAD_W-1:0];
        end
        nxt = least_loaded(open_n);
        r.assigned_server = SRV_W'(who + 1);
        r.next_server     = SRV_W'(nxt + 1);
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                results_seen++;
                if (result.load_saturated)
                    sat_seen++;
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("tb: result with nothing pending: %s",
                                 $sformatf("srv=%0d next=%0d sat=%0d",
                                           result.assigned_server, result.next_server,
                                           result.load_saturated));
                end
                else
                begin
                    got_want = pending_results.pop_front();
                    if (result !== got_want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("tb: mismatch: exp %s, got %s",
                                     $sformatf("srv=%0d next=%0d sat=%0d",
                                               got_want.assigned_server,
                                               got_want.next_server,
                                               got_want.load_saturated),
                                     $sformatf("srv=%0d next=%0d sat=%0d",
                                               result.assigned_server,
                                               result.next_server,
                                               result.load_saturated));
                    end
                end
            end
            if (start && !busy)
            begin
                predicted = predict_assignment(job);
                pending_results.push_back(use_typed ? typed_want : predicted);
                jobs_taken++;
            end
            if (cfg_we)
                model_active = cfg_wdata;
            if (done || (start && !busy))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    function automatic int pick_gap(bit burst);
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 8);
        if (r < 95)
            return $urandom_range(9, 25);
        return $urandom_range(26, 80);
    endfunction

    function automatic stim_row_t make_row(bit sc, int srv, int reps, int jt, bit nb,
                                           bit ty, int a, int n, int s);
        stim_row_t row;
        row.set_cfg = sc;
        row.servers = SRV_W'(srv);
        row.reps    = reps;
        row.item.job_time  = JOB_W'(jt);
        row.item.new_batch = nb;
        row.typed   = ty;
        row.want.assigned_server = SRV_W'(a);
        row.want.next_server     = SRV_W'(n);
        row.want.load_saturated  = s[0];
        return row;
    endfunction

    task automatic send_job(job_t j, int gap, bit ty, result_t w);
        if (gap > 0)
        begin
            @(negedge clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start      = 1'b1;
        job        = j;
        use_typed  = ty;
        typed_want = w;
        if (j.new_batch)
            batches_sent++;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic write_cfg(logic [SRV_W-1:0] value);
        @(negedge clk);
        start = 1'b0;
        while (pending_results.size() != 0 || busy)
            @(negedge clk);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we = 1'b0;
        cfg_writes++;
    endtask

    initial
    begin
        job_t    j;
        bit      burst;
        int      kind;
        int      pick;
        logic [SRV_W-1:0] servers;

        plan.push_back(make_row(0,  0, 1,     5, 0, 1, 1, 1, 0));
        plan.push_back(make_row(1,  0, 1,     0, 0, 1, 1, 1, 0));
        plan.push_back(make_row(1, 31, 1, 65535, 1, 1, 1, 2, 0));
        plan.push_back(make_row(0,  0, 1, 65535, 0, 1, 2, 3, 0));
        plan.push_back(make_row(0,  0, 1,     1, 0, 0, 0, 0, 0));
        plan.push_back(make_row(1, 16, 1,     0, 1, 1, 1, 1, 0));
        plan.push_back(make_row(0,  0, 1,   100, 0, 1, 1, 2, 0));
        plan.push_back(make_row(0,  0, 1,    50, 0, 1, 2, 3, 0));
        plan.push_back(make_row(1,  2, 1,    10, 0, 1, 2, 2, 0));
        plan.push_back(make_row(1,  3, 1,     7, 0, 1, 3, 3, 0));
        plan.push_back(make_row(1,  1, 1, 65535, 1, 0, 0, 0, 0));
        plan.push_back(make_row(0,  0, 1,     0, 0, 1, 1, 1, 0));
        plan.push_back(make_row(0,  0, 1,     1, 0, 1, 1, 1, 0));
        plan.push_back(make_row(0,  0, 1, 65535, 0, 1, 1, 1, 0));
        plan.push_back(make_row(1,  2, 1,     3, 0, 1, 2, 2, 0));
        plan.push_back(make_row(1, 16, 1, 21845, 0, 0, 0, 0, 0));
        plan.push_back(make_row(0,  0, 1, 43690, 1, 0, 0, 0, 0));
        plan.push_back(make_row(1, 17, 1,     1, 0, 0, 0, 0, 0));
        plan.push_back(make_row(1,  8, 1, 65535, 0, 0, 0, 0, 0));

        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        foreach (plan[k])
        begin
            if (plan[k].set_cfg)
                write_cfg(plan[k].servers);
            for (int r = 0; r < plan[k].reps; r++)
                send_job(plan[k].item, (plan[k].reps > 1) ? 0 : pick_gap(1'b0),
                         plan[k].typed, plan[k].want);
        end

        for (int p = 0; p < 14; p++)
        begin
            pick = $urandom_range(0, 9);
            if (p == 0)
                servers = SRV_W'(MAX_SERVERS);
            else if (p == 1)
                servers = SRV_W'(1);
            else if (pick == 0)
                servers = '0;
            else if (pick == 1)
                servers = SRV_W'($urandom_range(MAX_SERVERS + 1, 31));
            else
                servers = SRV_W'($urandom_range(1, MAX_SERVERS));
            write_cfg(servers);
            burst = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < 75; i++)
            begin
                kind = $urandom_range(0, 19);
                if (kind < 2)
                    j.job_time = '0;
                else if (kind < 10)
                    j.job_time = JOB_W'($urandom_range(1, 15));
                else if (kind < 18)
                    j.job_time = JOB_W'($urandom);
                else if (kind == 18)
                    j.job_time = '1;
                else
                    j.job_time = JOB_W'($urandom_range(65000, 65535));
                j.new_batch = ($urandom_range(0, 9) == 0);
                send_job(j, pick_gap(burst), 1'b0, '0);
            end
        end

        @(negedge clk);
        start = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("tb: %0d jobs (%0d new batches) over %0d server-count settings",
                 jobs_taken, batches_sent, cfg_writes);
        $display("tb: %0d results, %0d saturated, %0d mismatches",
                 results_seen, sat_seen, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
